// File: rtl/assert_macros.svh
// Assertion macros for the cipher RTL.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: label, clock, active-low reset, property.
`define SXKC_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sxkc assertion failed");

// Short form for modules that use clk_i and rst_ni.
`define SXKC_ASSERT(lbl, prop) \
  `SXKC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// File: rtl/sxkc_pkg.sv
// Types, register indexes and keystream helpers of the shift-XOR keystream cipher.
// Used by the core, the front end and the back end; depends on nothing.
`default_nettype none

package sxkc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD3 = 3'd3;

  // Operation codes of an input request.
  localparam logic OP_KEY_LOAD = 1'b0;
  localparam logic OP_DATA     = 1'b1;

  localparam logic [WordW-1:0] MASK_1B  = 32'hFF00_0000;
  localparam logic [WordW-1:0] MASK_2B  = 32'hFFFF_0000;
  localparam logic [WordW-1:0] MASK_3B  = 32'hFFFF_FF00;
  localparam logic [WordW-1:0] MASK_ALL = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] SCHED_SEED = 32'h0000_0001;

  localparam logic [CountW-1:0] COUNT_MIN = 3'd1;
  localparam logic [CountW-1:0] COUNT_MAX = 3'd4;

  // Command passed from the front end to the back end.
  typedef struct packed {
    logic              is_key;
    logic [WordW-1:0]  data;
    logic [WordW-1:0]  mask;
    logic [CountW-1:0] count;
  } cmd_t;

  // Result waiting for the consumer.
  typedef struct packed {
    logic [WordW-1:0]  data;
    logic [CountW-1:0] count;
  } res_t;

  // One register step: shift right once, then XOR four shifts of that value.
  function automatic logic [WordW-1:0] advance(input logic [WordW-1:0] r,
                                               input int unsigned l1,
                                               input int unsigned l2,
                                               input int unsigned r1,
                                               input int unsigned r2);
    logic [WordW-1:0] s;
    s = r >> 1;
    return (s << l1) ^ (s << l2) ^ (s >> r1) ^ (s >> r2);
  endfunction

endpackage

`default_nettype wire

// File: rtl/shift_xor_keystream_cipher_core.sv
// Shift-XOR keystream cipher core over four 32-bit shift registers.
//
// Input channel: a request is taken when push is high and full is low. op_i
// selects key load (runs the key schedule, gives no result) or data (gives one
// result). valid_bytes_i counts the leading valid bytes of data_in_i.
// Result channel: while empty is low the oldest result is on data_out_o and
// bytes_out_o; it is taken when pop is high. A stalled consumer fills the
// result queue, then the command queue, and then full rises.
// Configuration: cfg_valid_i/cfg_ready_o write key words 0 to 3; ready is
// always high. Key words are used when a key load reaches the back end.
// Throughput: one data request per cycle while the result queue has room and
// no key schedule runs, set by the single register update stage. A key load
// holds the back end for the key copy plus four schedule steps, one register
// per step.
// Reset clears the key words, the shift registers and both queues.
`default_nettype none

module shift_xor_keystream_cipher_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          op_i,
  input  wire logic [sxkc_pkg::WordW-1:0]    data_in_i,
  input  wire logic [sxkc_pkg::CountW-1:0]   valid_bytes_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic      [sxkc_pkg::WordW-1:0]    data_out_o,
  output logic      [sxkc_pkg::CountW-1:0]   bytes_out_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sxkc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sxkc_pkg::WordW-1:0]    cfg_data_i
);

  sxkc_pkg::cmd_t cmd_in, cmd_head;
  sxkc_pkg::res_t res_in, res_head;
  logic           cmd_push, cmd_pop, cmd_empty;
  logic           res_push, res_full;

  assign cfg_ready_o = 1'b1;

  sxkc_front u_front (
    .push_i        (push),
    .op_i          (op_i),
    .data_in_i     (data_in_i),
    .valid_bytes_i (valid_bytes_i),
    .queue_full_i  (full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  sxkc_fifo #(
    .Depth (QueueDepth),
    .Width ($bits(sxkc_pkg::cmd_t))
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  sxkc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_avail_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  sxkc_fifo #(
    .Depth (QueueDepth),
    .Width ($bits(sxkc_pkg::res_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty)
  );

  assign data_out_o  = res_head.data;
  assign bytes_out_o = res_head.count;

endmodule

`default_nettype wire

// File: rtl/sxkc_fifo.sv
// Small first-in first-out queue built from registers.
// Generic; used between front end and back end and on the result side.
`default_nettype none

module sxkc_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sxkc_front.sv
// Front end: takes input requests, classifies them and prepares the byte mask.
// Depends on sxkc_pkg.
`default_nettype none

module sxkc_front (
  input  wire logic                          push_i,
  input  wire logic                          op_i,
  input  wire logic [sxkc_pkg::WordW-1:0]    data_in_i,
  input  wire logic [sxkc_pkg::CountW-1:0]   valid_bytes_i,
  input  wire logic                          queue_full_i,
  output logic                               cmd_push_o,
  output sxkc_pkg::cmd_t                     cmd_o
);

  logic [sxkc_pkg::CountW-1:0] count;

  // Counts above four saturate, a count of zero is raised to one.
  always_comb begin
    if (valid_bytes_i > sxkc_pkg::COUNT_MAX) begin
      count = sxkc_pkg::COUNT_MAX;
    end else if (valid_bytes_i == '0) begin
      count = sxkc_pkg::COUNT_MIN;
    end else begin
      count = valid_bytes_i;
    end
  end

  always_comb begin
    cmd_o.is_key = (op_i == sxkc_pkg::OP_KEY_LOAD);
    cmd_o.data   = data_in_i;
    cmd_o.count  = count;
    unique case (count)
      3'd1:    cmd_o.mask = sxkc_pkg::MASK_1B;
      3'd2:    cmd_o.mask = sxkc_pkg::MASK_2B;
      3'd3:    cmd_o.mask = sxkc_pkg::MASK_3B;
      default: cmd_o.mask = sxkc_pkg::MASK_ALL;
    endcase
  end

  assign cmd_push_o = push_i && !queue_full_i;

endmodule

`default_nettype wire

// File: rtl/sxkc_back.sv
// Back end: key registers, the four shift registers, key schedule sequencer
// and keystream generation. Depends on sxkc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sxkc_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [sxkc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sxkc_pkg::WordW-1:0]    cfg_data_i,
  input  wire logic                          cmd_avail_i,
  input  wire sxkc_pkg::cmd_t                cmd_i,
  output logic                               cmd_pop_o,
  input  wire logic                          res_full_i,
  output logic                               res_push_o,
  output sxkc_pkg::res_t                     res_o
);

  typedef enum logic [1:0] {
    ST_READY = 2'b01,
    ST_SCHED = 2'b10
  } state_e;

  state_e                     state_q, state_d;
  logic [1:0]                 step_q, step_d;
  logic [sxkc_pkg::WordW-1:0] key_q [4];
  logic [sxkc_pkg::WordW-1:0] reg_q [4];
  logic [sxkc_pkg::WordW-1:0] reg_d [4];
  logic [sxkc_pkg::WordW-1:0] adv [4];
  logic [sxkc_pkg::WordW-1:0] tot_q, tot_d, sum_q, sum_d;
  logic [sxkc_pkg::WordW-1:0] key_tot, sched_val, keystream;

  // Key word registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sxkc_pkg::REG_KEY_WORD0: key_q[0] <= cfg_data_i;
        sxkc_pkg::REG_KEY_WORD1: key_q[1] <= cfg_data_i;
        sxkc_pkg::REG_KEY_WORD2: key_q[2] <= cfg_data_i;
        sxkc_pkg::REG_KEY_WORD3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv[0] = sxkc_pkg::advance(reg_q[0], 4, 3, 4, 3);
  assign adv[1] = sxkc_pkg::advance(reg_q[1], 3, 2, 4, 1);
  assign adv[2] = sxkc_pkg::advance(reg_q[2], 1, 2, 3, 1);
  assign adv[3] = sxkc_pkg::advance(reg_q[3], 2, 5, 4, 2);
  assign keystream = adv[0] ^ adv[1] ^ adv[2] ^ adv[3];

  assign key_tot   = key_q[0] + key_q[1] + key_q[2] + key_q[3];
  assign sched_val = sum_q + tot_q;

  assign res_o.data  = (cmd_i.data ^ keystream) & cmd_i.mask;
  assign res_o.count = cmd_i.count;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    tot_d      = tot_q;
    sum_d      = sum_q;
    reg_d      = reg_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      ST_READY: begin
        if (cmd_avail_i && cmd_i.is_key) begin
          cmd_pop_o = 1'b1;
          reg_d     = key_q;
          tot_d     = key_tot;
          sum_d     = key_tot + sxkc_pkg::SCHED_SEED;
          step_d    = '0;
          state_d   = ST_SCHED;
        end else if (cmd_avail_i && !res_full_i) begin
          cmd_pop_o  = 1'b1;
          res_push_o = 1'b1;
          reg_d      = adv;
        end
      end
      ST_SCHED: begin
        // The register being replaced is always at the head; the row rotates
        // so that after four steps every register is back in its place.
        reg_d[0] = reg_q[1];
        reg_d[1] = reg_q[2];
        reg_d[2] = reg_q[3];
        reg_d[3] = sched_val;
        sum_d    = sched_val;
        tot_d    = tot_q - reg_q[0] + sched_val;
        step_d   = step_q + 1'b1;
        if (step_q == 2'd3) begin
          state_d = ST_READY;
        end
      end
      default: state_d = ST_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READY;
      step_q  <= '0;
      for (int i = 0; i < 4; i++) begin
        reg_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      reg_q   <= reg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q <= tot_d;
    sum_q <= sum_d;
  end

  `SXKC_ASSERT(a_no_result_in_sched, (state_q == ST_SCHED) |-> !res_push_o)
  `SXKC_ASSERT(a_key_starts_sched,
               (cmd_pop_o && cmd_i.is_key) |=> (state_q == ST_SCHED && step_q == 2'd0))
  `SXKC_ASSERT(a_sched_ends, (state_q == ST_SCHED && step_q == 2'd3) |=> (state_q == ST_READY))
  `SXKC_ASSERT(a_result_count, res_push_o |-> (res_o.count >= sxkc_pkg::COUNT_MIN &&
                                               res_o.count <= sxkc_pkg::COUNT_MAX))

endmodule

`default_nettype wire
